[src/aip_pkg.sv]
// Shared widths, character codes and types for the ASCII integer parser.
package aip_pkg;

  localparam int NUM_W    = 64;
  localparam int OFFSET_W = 13;
  localparam int CHAR_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int DIGIT_W  = 6;
  localparam int PROD_W   = NUM_W + RADIX_W;

  localparam int MAX_LENGTH_DEFAULT = 4096;
  localparam int OFFSET_MAX         = 8191;

  localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [DIGIT_W-1:0] LETTER_BASE   = 6'd10;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPZ   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWZ  = 8'h7A;

  typedef struct packed {
    logic               space;
    logic               sign;
    logic               minus;
    logic               digit;
    logic [DIGIT_W-1:0] value;
    logic [RADIX_W-1:0] base;
  } aip_dec_t;

endpackage

[src/aip_in_reg.sv]
// Input register stage that captures one character transaction.
module aip_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [aip_pkg::CHAR_W-1:0] character,
  input  logic                       string_start,
  output logic                       item_valid,
  output logic [aip_pkg::CHAR_W-1:0] item_char,
  output logic                       item_start,
  input  logic                       item_take
);
  import aip_pkg::*;

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_char  <= character;
      item_start <= string_start;
    end
  end

endmodule

[src/aip_decode.sv]
// Character classifier: whitespace, sign and digit value in the active radix.
module aip_decode (
  input  logic [aip_pkg::CHAR_W-1:0]  item_char,
  input  logic [aip_pkg::RADIX_W-1:0] radix,
  output aip_pkg::aip_dec_t           dec
);
  import aip_pkg::*;

  logic is_num;
  logic is_low;
  logic is_up;

  always_comb begin
    is_num = (item_char >= CH_ZERO) && (item_char <= CH_NINE);
    is_low = (item_char >= CH_LOWA) && (item_char <= CH_LOWZ);
    is_up  = (item_char >= CH_UPA) && (item_char <= CH_UPZ);

    dec.base  = (radix == '0) ? RADIX_DEFAULT : radix;
    dec.space = (item_char == CH_SPACE) || ((item_char >= CH_TAB) && (item_char <= CH_CR));
    dec.sign  = (item_char == CH_MINUS) || (item_char == CH_PLUS);
    dec.minus = (item_char == CH_MINUS);

    if (is_num) begin
      dec.value = DIGIT_W'(item_char - CH_ZERO);
    end else if (is_low) begin
      dec.value = DIGIT_W'(item_char - CH_LOWA) + LETTER_BASE;
    end else if (is_up) begin
      dec.value = DIGIT_W'(item_char - CH_UPA) + LETTER_BASE;
    end else begin
      dec.value = '0;
    end

    dec.digit = (is_num || is_low || is_up) && (dec.value < dec.base);
  end

endmodule

[src/aip_core.sv]
// Parse state, multiply-accumulate step and result register.
module aip_core #(
  parameter int MAX_LENGTH = aip_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_start,
  input  aip_pkg::aip_dec_t            dec,
  output logic                         item_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [aip_pkg::NUM_W-1:0]    number,
  output logic [aip_pkg::OFFSET_W-1:0] end_offset,
  output logic                         overflowed
);
  import aip_pkg::*;

  localparam logic [OFFSET_W-1:0] POS_CAP =
    OFFSET_W'((MAX_LENGTH < OFFSET_MAX) ? MAX_LENGTH : OFFSET_MAX);

  typedef enum logic [1:0] {
    PH_DONE,
    PH_LEAD,
    PH_DIGITS
  } phase_t;

  phase_t              phase;
  phase_t              phase_next;
  logic [NUM_W-1:0]    acc;
  logic [NUM_W-1:0]    acc_next;
  logic                neg;
  logic                neg_next;
  logic [OFFSET_W-1:0] pos;
  logic [OFFSET_W-1:0] pos_next;
  logic                ovf;
  logic                ovf_next;
  logic                emit;
  logic                do_digit;

  phase_t              cur_phase;
  logic [NUM_W-1:0]    cur_acc;
  logic                cur_neg;
  logic [OFFSET_W-1:0] cur_pos;
  logic                cur_ovf;
  logic [OFFSET_W-1:0] pos_inc;
  logic [PROD_W-1:0]   mac;

  assign item_take = item_valid && (!out_valid || out_ready);

  always_comb begin
    cur_phase = item_start ? PH_LEAD : phase;
    cur_acc   = item_start ? '0 : acc;
    cur_neg   = item_start ? 1'b0 : neg;
    cur_pos   = item_start ? '0 : pos;
    cur_ovf   = item_start ? 1'b0 : ovf;
    pos_inc   = (cur_pos < POS_CAP) ? cur_pos + OFFSET_W'(1) : cur_pos;
    mac       = PROD_W'(cur_acc) * PROD_W'(dec.base) + PROD_W'(dec.value);

    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    pos_next   = pos;
    ovf_next   = ovf;
    emit       = 1'b0;
    do_digit   = 1'b0;

    if (item_take) begin
      phase_next = cur_phase;
      acc_next   = cur_acc;
      neg_next   = cur_neg;
      pos_next   = cur_pos;
      ovf_next   = cur_ovf;

      case (cur_phase)
        PH_LEAD: begin
          if (dec.space) begin
            pos_next = pos_inc;
          end else if (dec.sign) begin
            neg_next   = dec.minus;
            phase_next = PH_DIGITS;
            pos_next   = pos_inc;
          end else begin
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
        end
      endcase

      if (do_digit) begin
        if (dec.digit) begin
          acc_next   = mac[NUM_W-1:0];
          ovf_next   = cur_ovf || (mac[PROD_W-1:NUM_W] != '0);
          pos_next   = pos_inc;
          phase_next = PH_DIGITS;
        end else begin
          emit       = 1'b1;
          phase_next = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DONE;
      acc       <= '0;
      neg       <= 1'b0;
      pos       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      neg   <= neg_next;
      pos   <= pos_next;
      ovf   <= ovf_next;
      if (emit) begin
        out_valid  <= 1'b1;
        number     <= cur_neg ? (NUM_W'(0) - cur_acc) : cur_acc;
        end_offset <= cur_pos;
        overflowed <= cur_ovf;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_lead_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LEAD) |-> (acc == '0 && !neg && !ovf))
    else $error("Lead phase holds stale accumulation state.");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    emit |=> (phase == PH_DONE && out_valid))
    else $error("Result was not registered or parse did not finish.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !item_take)
    else $error("Item taken while a result waits.");

  a_offset_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_offset <= POS_CAP))
    else $error("End offset above its cap.");

endmodule

[src/ascii_integer_parser_top.sv]
// Top level of the ASCII integer parser with its radix register.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   character, string_start
//   output    out_valid / out_ready number, end_offset, overflowed
//   config    cfg_we                cfg_wdata (radix)
//
// One character per cycle is taken while no result waits; a result is registered when its
// terminating character leaves the input register. The accumulator update is one 64 by 6
// multiply-add per cycle, which sets the path between the input register and
// the state. Reset clears the parse state and sets the radix to 10. While a result
// waits, one further character can enter the input register; after that the input
// stalls until the result is taken.
module ascii_integer_parser_top #(
  parameter int MAX_LENGTH = aip_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aip_pkg::CHAR_W-1:0]    character,
  input  logic                          string_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aip_pkg::NUM_W-1:0]     number,
  output logic [aip_pkg::OFFSET_W-1:0]  end_offset,
  output logic                          overflowed,
  input  logic                          cfg_we,
  input  logic [aip_pkg::RADIX_W-1:0]   cfg_wdata
);
  import aip_pkg::*;

  logic [RADIX_W-1:0] radix;
  logic               item_valid;
  logic [CHAR_W-1:0]  item_char;
  logic               item_start;
  logic               item_take;
  aip_dec_t           dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  aip_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .character    (character),
    .string_start (string_start),
    .item_valid   (item_valid),
    .item_char    (item_char),
    .item_start   (item_start),
    .item_take    (item_take)
  );

  aip_decode u_decode (
    .item_char (item_char),
    .radix     (radix),
    .dec       (dec)
  );

  aip_core #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_start (item_start),
    .dec        (dec),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .number     (number),
    .end_offset (end_offset),
    .overflowed (overflowed)
  );

endmodule
